// ===== design/dcc_pkg.sv =====
// Shared types for the distinct color counter: channel words and the token control group.
`timescale 1ns / 1ps

package dcc_pkg;

	localparam int INDEX_FIELD_W = 7;
	localparam int COUNT_FIELD_W = 16;
	localparam int TOTAL_FIELD_W = 8;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} color_t;

	typedef struct packed {
		logic                     is_duplicate;
		logic [INDEX_FIELD_W-1:0] entry_index;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic [TOTAL_FIELD_W-1:0] unique_total;
		logic                     dropped;
	} result_t;

	// Control bits of a token moving down the cell row.
	typedef struct packed {
		logic valid;
		logic resolved;
		logic hit;
	} tok_ctl_t;

endpackage

// ===== design/dcc_cell.sv =====
// One table cell: holds one color and its count, and checks or claims for a passing token.
`timescale 1ns / 1ps

module dcc_cell #(
	parameter int CELL_IDX   = 0,
	parameter int IDX_W      = 7,
	parameter int FILL_W     = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [FILL_W-1:0]     fill_count,
	input  dcc_pkg::tok_ctl_t     ctl_in,
	input  logic [31:0]           color_in,
	input  logic [IDX_W-1:0]      idx_in,
	input  logic [COUNT_BITS-1:0] cnt_in,
	output dcc_pkg::tok_ctl_t     ctl_out,
	output logic [31:0]           color_out,
	output logic [IDX_W-1:0]      idx_out,
	output logic [COUNT_BITS-1:0] cnt_out,
	output logic                  insert
);
	import dcc_pkg::*;

	logic [31:0]           color_q;
	logic [COUNT_BITS-1:0] count_q;
	tok_ctl_t              ctl_q;
	logic [31:0]           tok_color_q;
	logic [IDX_W-1:0]      tok_idx_q;
	logic [COUNT_BITS-1:0] tok_cnt_q;

	logic                  filled;
	logic                  open_tok;
	logic                  match;
	logic [COUNT_BITS-1:0] count_inc;

	// Entries below the fill count hold written data; the first empty one is this cell
	// exactly when the fill count equals its index.
	assign filled    = FILL_W'(CELL_IDX) < fill_count;
	assign open_tok  = ctl_in.valid && !ctl_in.resolved;
	assign match     = open_tok && filled && (color_q == color_in);
	assign insert    = advance && open_tok && !filled;
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

	always_ff @(posedge clk) begin
		if (advance && match) begin
			count_q <= count_inc;
		end else if (insert) begin
			color_q <= color_in;
			count_q <= COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q.valid    <= ctl_in.valid;
			ctl_q.resolved <= ctl_in.resolved || match || (open_tok && !filled);
			ctl_q.hit      <= ctl_in.hit || match;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_color_q <= color_in;
			if (match) begin
				tok_idx_q <= IDX_W'(CELL_IDX);
				tok_cnt_q <= count_inc;
			end else if (open_tok && !filled) begin
				tok_idx_q <= IDX_W'(CELL_IDX);
				tok_cnt_q <= COUNT_BITS'(1);
			end else begin
				tok_idx_q <= idx_in;
				tok_cnt_q <= cnt_in;
			end
		end
	end

	assign ctl_out   = ctl_q;
	assign color_out = tok_color_q;
	assign idx_out   = tok_idx_q;
	assign cnt_out   = tok_cnt_q;

endmodule

// ===== design/distinct_color_counter.sv =====
// Top level of the distinct color counter: input stage, row of table cells, result stage.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Word
// color     in         color_valid/stall     dcc_pkg::color_t (red, green, blue, alpha)
// result    out        result_valid/stall    dcc_pkg::result_t
//
// A word enters the input stage, then visits one table cell per cycle while the row moves,
// and then the result register; the cell row carries one word per cycle while result_stall
// is low, so the sustained rate is then one word per cycle.
// Reset clears the fill count and all valid flags; table contents are left as they are.
// While a result waits under result_stall, the whole row freezes, table writes included,
// and color_stall is raised.

module distinct_color_counter #(
	parameter int TABLE_ENTRIES = 128,
	parameter int COUNT_BITS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             color_valid,
	output logic             color_stall,
	input  dcc_pkg::color_t  color,
	output logic             result_valid,
	input  logic             result_stall,
	output dcc_pkg::result_t result
);
	import dcc_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

	// Token lanes between cells; lane 0 is the input stage, the last lane feeds the result.
	tok_ctl_t              ctl_l   [TABLE_ENTRIES+1];
	logic [31:0]           color_l [TABLE_ENTRIES+1];
	logic [IDX_W-1:0]      idx_l   [TABLE_ENTRIES+1];
	logic [COUNT_BITS-1:0] cnt_l   [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] insert_v;

	logic                  advance;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     stored_q;
	tok_ctl_t              in_ctl_q;
	logic [31:0]           in_color_q;
	logic                  out_valid_q;
	result_t               out_q;

	tok_ctl_t              last_ctl;
	logic                  last_new;
	logic [FILL_W-1:0]     stored_next;
	logic [IDX_W+INDEX_FIELD_W-1:0]      idx_ext;
	logic [COUNT_BITS+COUNT_FIELD_W-1:0] cnt_ext;
	logic [FILL_W+TOTAL_FIELD_W-1:0]     total_ext;

	// The whole row moves together whenever the result register can take a word.
	assign advance     = !out_valid_q || !result_stall;
	assign color_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ctl_q <= '0;
		end else if (advance) begin
			in_ctl_q.valid    <= color_valid;
			in_ctl_q.resolved <= 1'b0;
			in_ctl_q.hit      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			in_color_q <= color;
		end
	end

	assign ctl_l[0]   = in_ctl_q;
	assign color_l[0] = in_color_q;
	assign idx_l[0]   = '0;
	assign cnt_l[0]   = '0;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			dcc_cell #(
				.CELL_IDX  (gi),
				.IDX_W     (IDX_W),
				.FILL_W    (FILL_W),
				.COUNT_BITS(COUNT_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.advance   (advance),
				.fill_count(fill_q),
				.ctl_in    (ctl_l[gi]),
				.color_in  (color_l[gi]),
				.idx_in    (idx_l[gi]),
				.cnt_in    (cnt_l[gi]),
				.ctl_out   (ctl_l[gi+1]),
				.color_out (color_l[gi+1]),
				.idx_out   (idx_l[gi+1]),
				.cnt_out   (cnt_l[gi+1]),
				.insert    (insert_v[gi])
			);
		end
	endgenerate

	// At most one cell claims an entry in a cycle: only the cell at the fill count can.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (|insert_v) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// The distinct total is counted as words leave the row, so each result sees exactly
	// the insertions of the words before it and its own.
	assign last_ctl    = ctl_l[TABLE_ENTRIES];
	assign last_new    = last_ctl.valid && last_ctl.resolved && !last_ctl.hit;
	assign stored_next = stored_q + FILL_W'(last_new);
	assign idx_ext     = {{INDEX_FIELD_W{1'b0}}, idx_l[TABLE_ENTRIES]};
	assign cnt_ext     = {{COUNT_FIELD_W{1'b0}}, cnt_l[TABLE_ENTRIES]};
	assign total_ext   = {{TOTAL_FIELD_W{1'b0}}, stored_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			stored_q    <= '0;
		end else if (advance) begin
			out_valid_q <= last_ctl.valid;
			stored_q    <= stored_next;
		end
	end

	// A word that passed every cell unclaimed found the table full and is dropped; its
	// index and count lanes still hold the zeros from the input stage.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.is_duplicate <= last_ctl.hit;
			out_q.entry_index  <= idx_ext[INDEX_FIELD_W-1:0];
			out_q.entry_count  <= cnt_ext[COUNT_FIELD_W-1:0];
			out_q.unique_total <= total_ext[TOTAL_FIELD_W-1:0];
			out_q.dropped      <= !last_ctl.resolved;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== design/dcc_checker.sv =====
// Port-level checks of the distinct color counter and their binding to the top level.
`timescale 1ns / 1ps

module dcc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input dcc_pkg::result_t result
);
	import dcc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dropped |->
			!result.is_duplicate && result.entry_index == '0 && result.entry_count == '0)
		else $error("dropped word carries entry data");

	a_dup: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_duplicate |-> !result.dropped && result.entry_count != '0)
		else $error("duplicate word with zero count or drop flag");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_duplicate && !result.dropped |->
			result.entry_count == COUNT_FIELD_W'(1) && result.unique_total != '0)
		else $error("newly stored color without count one");

endmodule

bind distinct_color_counter dcc_checker u_dcc_checker (.*);

// ===== bench/distinct_color_counter_tb.sv =====
// Self-checking testbench for the distinct color counter: directed, repeated-hit and random tests.
`timescale 1ns / 1ps

module distinct_color_counter_tb;

	import dcc_pkg::*;

	localparam int TABLE_ENTRIES = 128;
	localparam int COUNT_BITS    = 16;

	// A word visits the input stage and then one table cell per cycle while the row moves.
	localparam int LATENCY = TABLE_ENTRIES + 1;

	// The slowest correct run stays well under this limit: each of about 1750 words
	// pays at most a long sender gap and a long receiver stall, and each test drains
	// the pipeline.
	localparam int CYCLE_LIMIT = 1_000_000;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic    clk;
	logic    arst_n;
	logic    color_valid;
	logic    color_stall;
	color_t  color;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Our own copy of the color table, updated as each word is accepted.
	color_t                known_color [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] known_count [TABLE_ENTRIES];
	int unsigned           known_total;

	// Results still owed by the block, oldest first.
	result_t predicted_tallies [$];

	int unsigned mismatches;
	int unsigned cycles;

	// Idling switches for the sender and the receiver, and a request for a long
	// receiver hold that the stall process counts down itself.
	bit tx_idle_on;
	bit rx_idle_on;
	int hold_left;

	distinct_color_counter #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COUNT_BITS   (COUNT_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.color       (color),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Tally one color against our table exactly as the block should: a match bumps
	// the count up to its ceiling, a miss takes the next free entry, and a miss on a
	// full table is dropped with every other field at zero except the total.
	function automatic result_t tally_color(color_t c);
		result_t r;
		int      hit_at;
		hit_at = -1;
		r = '0;
		for (int i = 0; i < known_total; i++) begin
			if (known_color[i] == c) begin
				hit_at = i;
			end
		end
		if (hit_at >= 0) begin
			if (known_count[hit_at] != COUNT_MAX) begin
				known_count[hit_at] = known_count[hit_at] + 1'b1;
			end
			r.is_duplicate = 1'b1;
			r.entry_index  = INDEX_FIELD_W'(hit_at);
			r.entry_count  = COUNT_FIELD_W'(known_count[hit_at]);
		end else if (known_total < TABLE_ENTRIES) begin
			known_color[known_total] = c;
			known_count[known_total] = COUNT_BITS'(1);
			r.entry_index = INDEX_FIELD_W'(known_total);
			r.entry_count = COUNT_FIELD_W'(1);
			known_total++;
		end else begin
			r.dropped = 1'b1;
		end
		r.unique_total = TOTAL_FIELD_W'(known_total);
		return r;
	endfunction

	// Pick a color for the random tests: a stored color (a hit), a stored color with
	// one bit flipped (a near miss that stresses the compare), or anything at all.
	function automatic color_t pick_color(int hit_pct, int near_pct);
		int     roll;
		color_t c;
		roll = $urandom_range(99);
		c = color_t'($urandom);
		if (known_total > 0 && roll < hit_pct + near_pct) begin
			c = known_color[$urandom_range(known_total - 1)];
			if (roll >= hit_pct) begin
				c = c ^ color_t'(32'h1 << $urandom_range(31));
			end
		end
		return c;
	endfunction

	// Random sender gap: usually none, often a few cycles, now and then a long one.
	// While idle the payload carries junk, which the block must ignore.
	task automatic sender_pause();
		int roll;
		int gap;
		gap = 0;
		if (tx_idle_on) begin
			roll = $urandom_range(99);
			if (roll >= 95) begin
				gap = $urandom_range(40, 10);
			end else if (roll >= 70) begin
				gap = $urandom_range(3, 1);
			end
		end
		if (gap > 0) begin
			color_valid <= 1'b0;
			color       <= color_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Offer one word and hold it until the block takes it. Stall is sampled on the
	// falling edge, where nothing is changing, and the word counts as accepted at the
	// rising edge that follows a low stall. Called just after a rising edge.
	task automatic send_color(input color_t c);
		bit taken;
		color_valid <= 1'b1;
		color       <= c;
		do begin
			@(negedge clk);
			taken = !color_stall;
			@(posedge clk);
		end while (!taken);
		predicted_tallies.push_back(tally_color(c));
		sender_pause();
	endtask

	// Stop offering words, then wait until every owed result has come back.
	task automatic wait_for_drain();
		color_valid <= 1'b0;
		while (predicted_tallies.size() != 0) @(posedge clk);
	endtask

	// Corner colors: all zero, all ones, each channel alone, single-bit neighbors and
	// checkerboards, with back-to-back repeats so that a word matches the entry the
	// word just ahead of it has written.
	task automatic test_directed_colors();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_color(color_t'(32'h0000_0000));
		send_color(color_t'(32'h0000_0000));
		send_color(color_t'(32'hFFFF_FFFF));
		send_color(color_t'(32'hFF00_0000));
		send_color(color_t'(32'h00FF_0000));
		send_color(color_t'(32'h0000_FF00));
		send_color(color_t'(32'h0000_00FF));
		send_color(color_t'(32'hFFFF_FFFF));
		send_color(color_t'(32'h0000_0001));
		send_color(color_t'(32'h8000_0000));
		send_color(color_t'(32'h0000_0000));
		send_color(color_t'(32'hFFFF_FFFE));
		send_color(color_t'(32'h7FFF_FFFF));
		send_color(color_t'(32'hAA55_AA55));
		send_color(color_t'(32'h55AA_55AA));
		send_color(color_t'(32'h55AA_55AA));
		send_color(color_t'(32'h55AA_55AA));
		send_color(color_t'(32'hFF00_0000));
		wait_for_drain();
	endtask

	// Hammer entry zero back to back with no idling, so that every word hits the
	// count which the word just ahead of it has raised.
	task automatic test_repeat_hits();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (40) send_color(known_color[0]);
		wait_for_drain();
	endtask

	// Mostly hits on stored colors, with near misses and noise that fill the table
	// and then run into the full-table drop.
	task automatic test_random_fill();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (600) send_color(pick_color(55, 15));
		wait_for_drain();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// words back to back: the row fills up and the block has to stall its input.
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_left  = 400;
		repeat (200) send_color(pick_color(60, 20));
		rx_idle_on = 1'b1;
		wait_for_drain();
	endtask

	// Full table: hits keep counting and every new color is dropped.
	task automatic test_full_table();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (900) send_color(pick_color(60, 20));
		wait_for_drain();
	endtask

	// Receiver stall: a pending long hold wins, otherwise random runs of stall when
	// idling is on. Exactly one assignment per edge.
	initial begin : result_stall_driver
		int roll;
		int run;
		run = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (run > 0) begin
				result_stall <= 1'b1;
				run--;
			end else if (rx_idle_on) begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					result_stall <= 1'b0;
				end else if (roll < 97) begin
					result_stall <= 1'b1;
					run = $urandom_range(2);
				end else begin
					result_stall <= 1'b1;
					run = $urandom_range(60, 15);
				end
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Result side: valid, stall and the word are sampled on the falling edge and the
	// word is taken at the next rising edge, then compared with the oldest prediction.
	initial begin : result_checker
		bit      v;
		bit      s;
		result_t got;
		result_t want;
		forever begin
			@(negedge clk);
			v   = result_valid;
			s   = result_stall;
			got = result;
			@(posedge clk);
			if (arst_n && v && !s) begin
				if (predicted_tallies.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word, expected none, actual %h",
						$time, got);
				end else begin
					want = predicted_tallies.pop_front();
					check_field("is_duplicate", 32'(want.is_duplicate),
						32'(got.is_duplicate));
					check_field("entry_index", 32'(want.entry_index),
						32'(got.entry_index));
					check_field("entry_count", 32'(want.entry_count),
						32'(got.entry_count));
					check_field("unique_total", 32'(want.unique_total),
						32'(got.unique_total));
					check_field("dropped", 32'(want.dropped), 32'(got.dropped));
				end
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : test_sequence
		mismatches  = 0;
		known_total = 0;
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		hold_left   = 0;
		arst_n      <= 1'b0;
		color_valid <= 1'b0;
		color       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_colors();
		test_repeat_hits();
		test_random_fill();
		test_backpressure();
		test_full_table();

		// Idle the input and give any stray result time to show up.
		color_valid <= 1'b0;
		repeat (2 * LATENCY) @(posedge clk);
		if (predicted_tallies.size() != 0) begin
			mismatches++;
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, predicted_tallies.size());
		end
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
